// File: hdl/one_wire_bus_master_defines.svh
// ----------------------------------------------------------------------------
// one_wire_bus_master_defines
// assertion macros used by the one-wire bus master top level
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define OWBM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked check, also active during reset
`define OWBM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define OWBM_ASSERT(name, prop, msg)
`define OWBM_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: hdl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// types, codes and constants of the one-wire bus master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owbm_pkg;

  localparam int CfgW            = 12;
  localparam int NumCfg          = 8;
  localparam int ApbDataW        = 32;
  localparam int ApbAddrW        = 5;
  localparam int TdataInW        = 16;
  localparam int TdataOutW       = 16;
  localparam int CounterWidthDef = 12;
  localparam int BitsW           = 4;
  localparam int ByteW           = 8;

  localparam logic [CfgW-1:0] ResetLowDef     = 12'd720;
  localparam logic [CfgW-1:0] PresenceWaitDef = 12'd50;
  localparam logic [CfgW-1:0] ResetTailDef    = 12'd250;
  localparam logic [CfgW-1:0] SlotLowDef      = 12'd5;
  localparam logic [CfgW-1:0] WriteHoldDef    = 12'd60;
  localparam logic [CfgW-1:0] ReadSampleDef   = 12'd5;
  localparam logic [CfgW-1:0] ReadTailDef     = 12'd45;
  localparam logic [CfgW-1:0] RecoveryDef     = 12'd5;

  localparam logic [BitsW-1:0] BitsOne  = 4'd1;
  localparam logic [BitsW-1:0] BitsByte = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_SLOT_LOW = 4'd4,
    PH_WR_HOLD  = 4'd5,
    PH_RD_WAIT  = 4'd6,
    PH_RD_TAIL  = 4'd7,
    PH_RECOVER  = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_RESET   = 3'd1,
    OP_WR_BYTE = 3'd2,
    OP_RD_BYTE = 3'd3,
    OP_WR_BIT  = 3'd4,
    OP_RD_BIT  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_RESET_TAIL    = 3'd2,
    CFG_SLOT_LOW      = 3'd3,
    CFG_WRITE_HOLD    = 3'd4,
    CFG_READ_SAMPLE   = 3'd5,
    CFG_READ_TAIL     = 3'd6,
    CFG_RECOVERY      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] reset_low;
    logic [CfgW-1:0] presence_wait;
    logic [CfgW-1:0] reset_tail;
    logic [CfgW-1:0] slot_low;
    logic [CfgW-1:0] write_hold;
    logic [CfgW-1:0] read_sample;
    logic [CfgW-1:0] read_tail;
    logic [CfgW-1:0] recovery;
  } cfg_t;

  typedef struct packed {
    logic             rejected;
    logic [ByteW-1:0] read_data;
    logic             presence;
    logic             done_res;
    logic             busy_res;
    logic             drive_low;
  } res_t;

endpackage

// File: hdl/owbm_cfg.sv
// ----------------------------------------------------------------------------
// owbm_cfg
// phase length register file with write and read decode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owbm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [owbm_pkg::ApbAddrW-1:0] addr_i,
  input  logic [owbm_pkg::ApbDataW-1:0] wdata_i,
  output logic [owbm_pkg::ApbDataW-1:0] rdata_o,
  output owbm_pkg::cfg_t                cfg_o
);
  import owbm_pkg::*;

  cfg_t            cfg_q;
  cfg_t            cfg_d;
  cfg_idx_e        idx;
  logic [CfgW-1:0] wval;
  logic [CfgW-1:0] rval;

  assign idx  = cfg_idx_e'(addr_i[ApbAddrW-1:2]);
  assign wval = wdata_i[CfgW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (idx)
        CFG_RESET_LOW:     cfg_d.reset_low     = wval;
        CFG_PRESENCE_WAIT: cfg_d.presence_wait = wval;
        CFG_RESET_TAIL:    cfg_d.reset_tail    = wval;
        CFG_SLOT_LOW:      cfg_d.slot_low      = wval;
        CFG_WRITE_HOLD:    cfg_d.write_hold    = wval;
        CFG_READ_SAMPLE:   cfg_d.read_sample   = wval;
        CFG_READ_TAIL:     cfg_d.read_tail     = wval;
        CFG_RECOVERY:      cfg_d.recovery      = wval;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_RESET_LOW:     rval = cfg_q.reset_low;
      CFG_PRESENCE_WAIT: rval = cfg_q.presence_wait;
      CFG_RESET_TAIL:    rval = cfg_q.reset_tail;
      CFG_SLOT_LOW:      rval = cfg_q.slot_low;
      CFG_WRITE_HOLD:    rval = cfg_q.write_hold;
      CFG_READ_SAMPLE:   rval = cfg_q.read_sample;
      CFG_READ_TAIL:     rval = cfg_q.read_tail;
      CFG_RECOVERY:      rval = cfg_q.recovery;
      default:           rval = '0;
    endcase
  end

  assign rdata_o = ApbDataW'(rval);
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= ResetLowDef;
      cfg_q.presence_wait <= PresenceWaitDef;
      cfg_q.reset_tail    <= ResetTailDef;
      cfg_q.slot_low      <= SlotLowDef;
      cfg_q.write_hold    <= WriteHoldDef;
      cfg_q.read_sample   <= ReadSampleDef;
      cfg_q.read_tail     <= ReadTailDef;
      cfg_q.recovery      <= RecoveryDef;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hdl/owbm_seq.sv
// ----------------------------------------------------------------------------
// owbm_seq
// one-wire phase sequencer, advanced by one tick per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owbm_seq #(
  parameter int CounterWidth = owbm_pkg::CounterWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [2:0]                 op_i,
  input  logic [owbm_pkg::ByteW-1:0] data_i,
  input  logic                       line_i,
  input  owbm_pkg::cfg_t             cfg_i,
  output owbm_pkg::res_t             res_o,
  output logic                       idle_o
);
  import owbm_pkg::*;

  localparam int CmpW = (CounterWidth > CfgW) ? CounterWidth : CfgW;
  localparam logic [CmpW-1:0] MaxLen = CmpW'((64'd1 << CounterWidth) - 64'd1);

  phase_e                  phase_q, phase_d;
  logic [CounterWidth-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]        shift_q, shift_d;
  logic [BitsW-1:0]        bits_q, bits_d;
  logic [2:0]              kind_q, kind_d;
  logic                    pres_q, pres_d;
  logic [ByteW-1:0]        rdres_q, rdres_d;
  logic                    valid_op;

  // zero acts as one, long values clip to the counter range
  function automatic logic [CounterWidth-1:0] len_of(input logic [CfgW-1:0] v);
    logic [CmpW-1:0] w;
    w = CmpW'(v);
    if (w == '0) w = CmpW'(1);
    if (w > MaxLen) w = MaxLen;
    return w[CounterWidth-1:0];
  endfunction

  assign valid_op = (op_i >= OP_RESET) && (op_i <= OP_RD_BIT);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    kind_d  = kind_q;
    pres_d  = pres_q;
    rdres_d = rdres_q;
    res_o   = '0;
    if (step_i) begin
      if (phase_d == PH_IDLE) begin
        if (valid_op) begin
          kind_d = op_i;
          if (op_i == OP_RESET) begin
            phase_d = PH_RST_LOW;
            cnt_d   = len_of(cfg_i.reset_low);
          end else begin
            bits_d = ((op_i == OP_WR_BIT) || (op_i == OP_RD_BIT)) ? BitsOne : BitsByte;
            if ((op_i == OP_RD_BYTE) || (op_i == OP_RD_BIT)) begin
              shift_d = '0;
            end else if (op_i == OP_WR_BIT) begin
              shift_d = {{(ByteW-1){1'b0}}, data_i[0]};
            end else begin
              shift_d = data_i;
            end
            phase_d = PH_SLOT_LOW;
            cnt_d   = len_of(cfg_i.slot_low);
          end
        end
      end else if (valid_op) begin
        res_o.rejected = 1'b1;
      end

      if (phase_d != PH_IDLE) begin
        res_o.busy_res  = 1'b1;
        res_o.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_SLOT_LOW) ||
                          ((phase_d == PH_WR_HOLD) && !shift_d[0]);
        cnt_d = cnt_d - CounterWidth'(1);
        if (cnt_d == '0) begin
          case (phase_d)
            PH_RST_LOW: begin
              phase_d = PH_RST_WAIT;
              cnt_d   = len_of(cfg_i.presence_wait);
            end
            PH_RST_WAIT: begin
              pres_d  = !line_i;
              phase_d = PH_RST_TAIL;
              cnt_d   = len_of(cfg_i.reset_tail);
            end
            PH_RST_TAIL: begin
              phase_d        = PH_IDLE;
              res_o.done_res = 1'b1;
            end
            PH_SLOT_LOW: begin
              if ((kind_d == OP_RD_BYTE) || (kind_d == OP_RD_BIT)) begin
                phase_d = PH_RD_WAIT;
                cnt_d   = len_of(cfg_i.read_sample);
              end else begin
                phase_d = PH_WR_HOLD;
                cnt_d   = len_of(cfg_i.write_hold);
              end
            end
            PH_WR_HOLD: begin
              phase_d = PH_RECOVER;
              cnt_d   = len_of(cfg_i.recovery);
            end
            PH_RD_WAIT: begin
              if (kind_d == OP_RD_BIT) begin
                shift_d = {{(ByteW-1){1'b0}}, line_i};
              end else begin
                shift_d = {line_i, shift_d[ByteW-1:1]};
              end
              phase_d = PH_RD_TAIL;
              cnt_d   = len_of(cfg_i.read_tail);
            end
            PH_RD_TAIL: begin
              phase_d = PH_RECOVER;
              cnt_d   = len_of(cfg_i.recovery);
            end
            PH_RECOVER: begin
              if (!((kind_d == OP_RD_BYTE) || (kind_d == OP_RD_BIT))) begin
                shift_d = {1'b0, shift_d[ByteW-1:1]};
              end
              bits_d = bits_d - BitsW'(1);
              if (bits_d == '0) begin
                if ((kind_d == OP_RD_BYTE) || (kind_d == OP_RD_BIT)) rdres_d = shift_d;
                phase_d        = PH_IDLE;
                res_o.done_res = 1'b1;
              end else begin
                phase_d = PH_SLOT_LOW;
                cnt_d   = len_of(cfg_i.slot_low);
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
      res_o.presence  = pres_d;
      res_o.read_data = rdres_d;
    end
  end

  assign idle_o = (phase_q == PH_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      shift_q <= '0;
      bits_q  <= '0;
      kind_q  <= OP_NONE;
      pres_q  <= 1'b0;
      rdres_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      kind_q  <= kind_d;
      pres_q  <= pres_d;
      rdres_q <= rdres_d;
    end
  end

endmodule

// File: hdl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// one-wire bus master stepped, while m_axis does not stall, by one tick word per cycle
// ----------------------------------------------------------------------------
// channel   dir  handshake                  word
// s_axis    in   tvalid / tready            one tick: operation, data, line
// m_axis    out  tvalid / tready            one result per tick word
// apb       in   psel / penable / pready    phase length registers
//
// one tick word per cycle; each word is applied to the phase sequencer in the
// cycle it is taken and its result lands in the output register on that edge
// the output register is the only stage: a new word is taken while the held
// result is being taken, so a stall on m_axis stalls s_axis in the same cycle
// reset clears the sequencer and the output valid flag and loads the default
// phase lengths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "one_wire_bus_master_defines.svh"

module one_wire_bus_master #(
  parameter int COUNTER_WIDTH = owbm_pkg::CounterWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] operation, [10:3] data, [11] line_level, [15:12] zero
  input  logic [owbm_pkg::TdataInW-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
  // [11:4] read_data, [12] rejected, [15:13] zero
  output logic [owbm_pkg::TdataOutW-1:0] m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [owbm_pkg::ApbAddrW-1:0]  paddr,
  input  logic [owbm_pkg::ApbDataW-1:0]  pwdata,
  output logic [owbm_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import owbm_pkg::*;

  cfg_t                 cfg;
  res_t                 res;
  logic                 s_accept;
  logic                 seq_idle;
  logic                 m_valid_q, m_valid_d;
  logic [TdataOutW-1:0] m_data_q, m_data_d;

  assign pready        = 1'b1;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  owbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (psel && penable && pwrite && pready),
    .addr_i  (paddr),
    .wdata_i (pwdata),
    .rdata_o (prdata),
    .cfg_o   (cfg)
  );

  owbm_seq #(
    .CounterWidth (COUNTER_WIDTH)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s_accept),
    .op_i   (s_axis_tdata[2:0]),
    .data_i (s_axis_tdata[10:3]),
    .line_i (s_axis_tdata[11]),
    .cfg_i  (cfg),
    .res_o  (res),
    .idle_o (seq_idle)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (s_accept) begin
      m_valid_d = 1'b1;
      m_data_d  = TdataOutW'(res);
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // a word that ends a command leaves the sequencer idle for the next one
  `OWBM_ASSERT(a_done_then_idle, (s_accept && res.done_res) |=> seq_idle, "done did not return to idle")
  // a command is only refused while one is in progress
  `OWBM_ASSERT(a_reject_when_busy, (s_accept && res.rejected) |-> !seq_idle, "rejected while idle")
  // the bus is only pulled low during a command
  `OWBM_ASSERT(a_drive_needs_busy, (m_valid_q && m_data_q[0]) |-> m_data_q[1], "drive low while not busy")
  // nothing is held for output straight out of reset
  `OWBM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_valid_q || rst_ni, "output valid after reset")

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the one-wire bus master
// ----------------------------------------------------------------------------
// one tick word per handshake; every accepted word is run through a local
// model of the phase sequencer and the result word it should give is queued
// result words are checked field by field in order; a short directed table
// runs first, then random phases with random phase lengths; both stream
// sides idle and stall at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import owbm_pkg::*;

  localparam int HoldCycles    = 300;
  localparam int RandPhases    = 6;
  localparam int WordsPerPhase = 200;
  localparam int FirstZeroRow  = 4;
  localparam int NumRows       = 22;
  localparam logic [CfgW-1:0] CntMax   = CfgW'((1 << CounterWidthDef) - 1);
  localparam logic [2:0]      OpSpare6 = 3'd6;
  localparam logic [2:0]      OpSpare7 = 3'd7;

  typedef struct packed {
    logic             line;
    logic [ByteW-1:0] data;
    logic [2:0]       op;
  } tick_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [ByteW-1:0] data;
    logic             line;
    logic             run_out;
    logic             typed;
    res_t             res;
  } row_t;

  localparam res_t ResIdle = '0;
  localparam res_t ResLowStart = '{rejected: 1'b0, read_data: 8'h00, presence: 1'b0,
                                   done_res: 1'b0, busy_res: 1'b1, drive_low: 1'b1};
  localparam res_t ResLowPres  = '{rejected: 1'b0, read_data: 8'h00, presence: 1'b1,
                                   done_res: 1'b0, busy_res: 1'b1, drive_low: 1'b1};
  localparam res_t ResRejDone  = '{rejected: 1'b1, read_data: 8'h00, presence: 1'b0,
                                   done_res: 1'b1, busy_res: 1'b1, drive_low: 1'b0};

  // rows before FirstZeroRow run at reset lengths, the rest with every length 0
  localparam row_t DirRows [NumRows] = '{
    '{OP_NONE,    8'h00, 1'b1, 1'b0, 1'b1, ResIdle},
    '{OpSpare7,   8'hff, 1'b0, 1'b0, 1'b1, ResIdle},
    '{OpSpare6,   8'ha5, 1'b1, 1'b0, 1'b1, ResIdle},
    '{OP_WR_BIT,  8'h01, 1'b1, 1'b1, 1'b1, ResLowStart},
    '{OP_RESET,   8'h00, 1'b0, 1'b1, 1'b1, ResLowStart},
    '{OP_RESET,   8'h00, 1'b1, 1'b1, 1'b1, ResLowPres},
    '{OP_WR_BYTE, 8'h00, 1'b1, 1'b1, 1'b0, ResIdle},
    '{OP_WR_BYTE, 8'hff, 1'b1, 1'b1, 1'b0, ResIdle},
    '{OP_WR_BYTE, 8'h5a, 1'b0, 1'b1, 1'b0, ResIdle},
    '{OP_RD_BYTE, 8'h00, 1'b0, 1'b1, 1'b0, ResIdle},
    '{OP_RD_BYTE, 8'h00, 1'b1, 1'b1, 1'b0, ResIdle},
    '{OP_WR_BIT,  8'hfe, 1'b1, 1'b1, 1'b0, ResIdle},
    '{OP_WR_BIT,  8'h01, 1'b0, 1'b1, 1'b0, ResIdle},
    '{OP_RD_BIT,  8'h00, 1'b1, 1'b1, 1'b0, ResIdle},
    '{OP_RD_BIT,  8'hff, 1'b0, 1'b1, 1'b0, ResIdle},
    // back to back: command on the finishing tick, then one on the idle tick
    '{OP_WR_BIT,  8'h01, 1'b1, 1'b0, 1'b0, ResIdle},
    '{OP_NONE,    8'h00, 1'b1, 1'b0, 1'b0, ResIdle},
    '{OP_RD_BIT,  8'h00, 1'b1, 1'b0, 1'b1, ResRejDone},
    '{OP_RESET,   8'h00, 1'b0, 1'b0, 1'b1, ResLowStart},
    '{OP_RD_BYTE, 8'h00, 1'b1, 1'b0, 1'b0, ResIdle},
    '{OpSpare7,   8'h00, 1'b0, 1'b1, 1'b0, ResIdle},
    '{OP_WR_BYTE, 8'h80, 1'b1, 1'b1, 1'b0, ResIdle}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TdataInW-1:0]   s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TdataOutW-1:0]  m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ApbAddrW-1:0]   paddr;
  logic [ApbDataW-1:0]   pwdata;
  logic [ApbDataW-1:0]   prdata;
  logic                  pready;

  // local copy of the sequencer
  phase_e            bus_phase;
  logic [CfgW-1:0]   phase_left;
  logic [ByteW-1:0]  shift_reg;
  logic [BitsW-1:0]  bits_left;
  logic [2:0]        active_op;
  logic              presence_seen;
  logic [ByteW-1:0]  last_read;
  logic [CfgW-1:0]   phase_len_regs [NumCfg];
  logic [CfgW-1:0]   planned_regs [NumCfg];

  res_t tick_results_q [$];
  int   fail_count;
  bit   calm;
  bit   hold_req;
  logic row_has_res;
  res_t row_res;

  one_wire_bus_master u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [CfgW-1:0] ticks_of(cfg_idx_e idx);
    logic [CfgW-1:0] v;
    v = phase_len_regs[idx];
    if (v == '0) v = CfgW'(1);
    if (v > CntMax) v = CntMax;
    return v;
  endfunction

  function automatic void enter_phase(phase_e p, cfg_idx_e idx);
    bus_phase  = p;
    phase_left = ticks_of(idx);
  endfunction

  function automatic res_t step_bus(logic [2:0] op, logic [ByteW-1:0] data, logic line);
    res_t r;
    logic cmd_ok;
    logic is_rd;
    r = '0;
    cmd_ok = (op >= OP_RESET) && (op <= OP_RD_BIT);
    if (bus_phase == PH_IDLE) begin
      if (cmd_ok) begin
        active_op = op;
        if (op == OP_RESET) begin
          enter_phase(PH_RST_LOW, CFG_RESET_LOW);
        end else begin
          bits_left = (op == OP_WR_BIT || op == OP_RD_BIT) ? BitsOne : BitsByte;
          if (op == OP_RD_BYTE || op == OP_RD_BIT) shift_reg = '0;
          else if (op == OP_WR_BIT) shift_reg = {7'd0, data[0]};
          else shift_reg = data;
          enter_phase(PH_SLOT_LOW, CFG_SLOT_LOW);
        end
      end
    end else if (cmd_ok) begin
      r.rejected = 1'b1;
    end
    if (bus_phase != PH_IDLE) begin
      r.busy_res  = 1'b1;
      r.drive_low = (bus_phase == PH_RST_LOW) || (bus_phase == PH_SLOT_LOW) ||
                    (bus_phase == PH_WR_HOLD && !shift_reg[0]);
      phase_left = phase_left - CfgW'(1);
      if (phase_left == '0) begin
        is_rd = (active_op == OP_RD_BYTE) || (active_op == OP_RD_BIT);
        case (bus_phase)
          PH_RST_LOW:  enter_phase(PH_RST_WAIT, CFG_PRESENCE_WAIT);
          PH_RST_WAIT: begin
            presence_seen = !line;
            enter_phase(PH_RST_TAIL, CFG_RESET_TAIL);
          end
          PH_RST_TAIL: begin
            bus_phase  = PH_IDLE;
            r.done_res = 1'b1;
          end
          PH_SLOT_LOW: begin
            if (is_rd) enter_phase(PH_RD_WAIT, CFG_READ_SAMPLE);
            else enter_phase(PH_WR_HOLD, CFG_WRITE_HOLD);
          end
          PH_WR_HOLD:  enter_phase(PH_RECOVER, CFG_RECOVERY);
          PH_RD_WAIT: begin
            if (active_op == OP_RD_BIT) shift_reg = {7'd0, line};
            else shift_reg = {line, shift_reg[ByteW-1:1]};
            enter_phase(PH_RD_TAIL, CFG_READ_TAIL);
          end
          PH_RD_TAIL:  enter_phase(PH_RECOVER, CFG_RECOVERY);
          PH_RECOVER: begin
            if (!is_rd) shift_reg = shift_reg >> 1;
            bits_left = bits_left - BitsW'(1);
            if (bits_left == '0) begin
              if (is_rd) last_read = shift_reg;
              bus_phase  = PH_IDLE;
              r.done_res = 1'b1;
            end else begin
              enter_phase(PH_SLOT_LOW, CFG_SLOT_LOW);
            end
          end
          default:     bus_phase = PH_IDLE;
        endcase
      end
    end
    r.presence  = presence_seen;
    r.read_data = last_read;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [CfgW-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 75) return CfgW'($urandom_range(1, 4));
    if (r < 95) return CfgW'($urandom_range(5, 12));
    return CfgW'($urandom_range(13, 40));
  endfunction

  function automatic tick_t random_tick();
    tick_t w;
    int r;
    r = $urandom_range(0, 99);
    w.data = ByteW'($urandom_range(0, 255));
    w.line = 1'($urandom_range(0, 1));
    if (bus_phase == PH_IDLE) begin
      if (r < 70) w.op = 3'($urandom_range(OP_RESET, OP_RD_BIT));
      else if (r < 85) w.op = OP_NONE;
      else w.op = 3'($urandom_range(OpSpare6, OpSpare7));
    end else begin
      if (r < 92) w.op = OP_NONE;
      else if (r < 97) w.op = 3'($urandom_range(OP_RESET, OP_RD_BIT));
      else w.op = 3'($urandom_range(OpSpare6, OpSpare7));
    end
    return w;
  endfunction

  // entered and left at a falling edge
  task automatic drive_word(tick_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TdataInW'(w);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic run_to_idle(logic line);
    tick_t w;
    while (bus_phase != PH_IDLE) begin
      w.op   = OP_NONE;
      w.data = ByteW'($urandom_range(0, 255));
      w.line = line;
      drive_word(w);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (tick_results_q.size() != 0);
  endtask

  task automatic apply_regs();
    int j;
    logic [ApbDataW-1:0] word;
    for (j = 0; j < NumCfg; j++) begin
      word = $urandom();
      word[CfgW-1:0] = planned_regs[j];
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ApbAddrW'(j * 4);
      pwdata  <= word;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      phase_len_regs[j] = planned_regs[j];
      @(negedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result check first, then the model step for the word taken on this edge
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
        if (tick_results_q.size() == 0) begin
          $error("result word %h with nothing expected", m_axis_tdata);
          fail_count++;
        end else begin
          want = tick_results_q.pop_front();
          compare_field("drive_low", int'(want.drive_low), int'(got.drive_low));
          compare_field("busy_res", int'(want.busy_res), int'(got.busy_res));
          compare_field("done_res", int'(want.done_res), int'(got.done_res));
          compare_field("presence", int'(want.presence), int'(got.presence));
          compare_field("read_data", int'(want.read_data), int'(got.read_data));
          compare_field("rejected", int'(want.rejected), int'(got.rejected));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = step_bus(s_axis_tdata[2:0], s_axis_tdata[10:3], s_axis_tdata[11]);
        if (row_has_res) want = row_res;
        tick_results_q.push_back(want);
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  initial begin
    int i;
    int k;
    int n;
    tick_t w;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_count    = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    row_has_res   = 1'b0;
    row_res       = '0;
    bus_phase     = PH_IDLE;
    phase_left    = '0;
    shift_reg     = '0;
    bits_left     = '0;
    active_op     = OP_NONE;
    presence_seen = 1'b0;
    last_read     = '0;
    phase_len_regs[CFG_RESET_LOW]     = ResetLowDef;
    phase_len_regs[CFG_PRESENCE_WAIT] = PresenceWaitDef;
    phase_len_regs[CFG_RESET_TAIL]    = ResetTailDef;
    phase_len_regs[CFG_SLOT_LOW]      = SlotLowDef;
    phase_len_regs[CFG_WRITE_HOLD]    = WriteHoldDef;
    phase_len_regs[CFG_READ_SAMPLE]   = ReadSampleDef;
    phase_len_regs[CFG_READ_TAIL]     = ReadTailDef;
    phase_len_regs[CFG_RECOVERY]      = RecoveryDef;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < NumRows; i++) begin
      if (i == FirstZeroRow) begin
        drain_results();
        for (k = 0; k < NumCfg; k++) planned_regs[k] = '0;
        apply_regs();
      end
      w.op        = DirRows[i].op;
      w.data      = DirRows[i].data;
      w.line      = DirRows[i].line;
      row_has_res = DirRows[i].typed;
      row_res     = DirRows[i].res;
      drive_word(w);
      row_has_res = 1'b0;
      if (DirRows[i].run_out) run_to_idle(DirRows[i].line);
    end

    for (k = 0; k < RandPhases; k++) begin
      run_to_idle(1'($urandom_range(0, 1)));
      drain_results();
      for (n = 0; n < NumCfg; n++) planned_regs[n] = pick_len();
      apply_regs();
      calm = (k == 2);
      if (k == 1) hold_req = 1'b1;
      for (n = 0; n < WordsPerPhase; n++) drive_word(random_tick());
    end

    run_to_idle(1'b1);
    s_axis_tvalid <= 1'b0;

    while (tick_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/owbm_pkg.sv
hdl/owbm_cfg.sv
hdl/owbm_seq.sv
hdl/one_wire_bus_master.sv
test/tb.sv
